// ===== sv/serial_frame_receiver_crc16_assert.svh =====
// Assertion macros for the serial frame receiver.
// Used by the receiver RTL, which carries concurrent checks; expects clk and arst_n in scope.
`ifndef SERIAL_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFR_ASSERT_IMP(lbl, ante, cons, msg)
`define SFR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sfr_pkg.sv =====
// Shared constants and types of the serial frame receiver.
// No dependencies; imported by every other file but the assertion header.
`default_nettype none
package sfr_pkg;
	localparam int BUF_DEPTH  = 64;
	localparam int POS_W      = $clog2(BUF_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 6;
	localparam int CRC_W      = 16;
	localparam int END_W      = BYTE_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] DEST_MAX   = 8'h07;
	localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
	localparam logic [CRC_W-1:0]  POLY_RESET = 16'hA001;
	localparam logic [END_W-1:0]  LEN_OFFSET = 9'd5;

	localparam logic [CFG_IDX_W-1:0] REG_HOST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WR_OP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RD_OP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLY  = 2'd3;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CRC_W-1:0]  crc_t;

	typedef struct packed {
		logic init;
		logic xor_en;
		logic shift;
	} crc_ctrl_t;
endpackage
`default_nettype wire

// ===== sv/sfr_rx_if.sv =====
// Receive channel: one serial byte per word, valid/ready handshake.
// Depends on sfr_pkg.
`default_nettype none
interface sfr_rx_if;
	import sfr_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/sfr_frame_if.sv =====
// Frame output channel: one frame byte per word with its index and last mark.
// Depends on sfr_pkg.
`default_nettype none
interface sfr_frame_if;
	import sfr_pkg::*;
	logic             valid;
	logic             ready;
	byte_t            frame_byte;
	logic [IDX_W-1:0] byte_index;
	logic             frame_last;
	modport source (output valid, output frame_byte, output byte_index, output frame_last,
		input ready);
	modport sink (input valid, input frame_byte, input byte_index, input frame_last,
		output ready);
endinterface
`default_nettype wire

// ===== sv/sfr_crc_unit.sv =====
// Bit-serial reflected CRC-16 engine: load, fold in a byte, one shift per cycle while shift is set.
// Depends on sfr_pkg.
`default_nettype none
module sfr_crc_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  sfr_pkg::crc_ctrl_t ctrl,
	input  sfr_pkg::byte_t     data,
	input  sfr_pkg::crc_t      poly,
	output sfr_pkg::crc_t      crc
);
	import sfr_pkg::*;

	crc_t crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.xor_en) begin
			crc_q <= crc_q ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		end else if (ctrl.shift) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ poly) : (crc_q >> 1);
		end
	end

	assign crc = crc_q;
endmodule
`default_nettype wire

// ===== sv/sfr_frame_ram.sv =====
// Frame buffer: one write port, one read port with registered, held read data.
// Depends on sfr_pkg.
`default_nettype none
module sfr_frame_ram (
	input  logic           clk,
	input  logic           we,
	input  sfr_pkg::pos_t  waddr,
	input  sfr_pkg::byte_t wdata,
	input  logic           re,
	input  sfr_pkg::pos_t  raddr,
	output sfr_pkg::byte_t rdata
);
	import sfr_pkg::*;

	byte_t mem [BUF_DEPTH];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== sv/serial_frame_receiver_crc16.sv =====
// Serial frame receiver with reflected CRC-16 check; one received byte per input word.
// Header and payload bytes are taken at one word per cycle while no check or emission runs. The
// CRC high byte starts a check: the bit-serial CRC unit walks the L+4 covered bytes, each through
// read, XOR and shift states, then a compare state; a good frame leaves as L+6 words, each read, then loaded.
// Reset: position 0, CRC 0xFFFF, registers to defaults (polynomial 0xA001); no clearing pass.
`default_nettype none
`include "serial_frame_receiver_crc16_assert.svh"
module serial_frame_receiver_crc16 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	sfr_rx_if.sink                         rx,
	sfr_frame_if.source                    frame
);
	import sfr_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CRC_RD  = 3'd1;
	localparam logic [2:0] ST_CRC_XOR = 3'd2;
	localparam logic [2:0] ST_CRC_SH  = 3'd3;
	localparam logic [2:0] ST_CHECK   = 3'd4;
	localparam logic [2:0] ST_EMIT_RD = 3'd5;
	localparam logic [2:0] ST_EMIT_LD = 3'd6;

	// configuration registers
	byte_t host_q, wr_op_q, rd_op_q;
	crc_t  poly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_q  <= '0;
			wr_op_q <= '0;
			rd_op_q <= '0;
			poly_q  <= POLY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOST:  host_q  <= cfg_data[BYTE_W-1:0];
				REG_WR_OP: wr_op_q <= cfg_data[BYTE_W-1:0];
				REG_RD_OP: rd_op_q <= cfg_data[BYTE_W-1:0];
				REG_POLY:  poly_q  <= cfg_data[CRC_W-1:0];
				default: ;
			endcase
		end
	end

	logic [2:0] state_q;
	pos_t       pos_q;
	pos_t       idx_q;     // shared walk counter: CRC pass, then emission
	pos_t       end_q;     // position of the CRC high byte
	logic [2:0] bit_q;

	// copies of header bytes 0..3, so the header can be re-checked without a read
	byte_t hdr0_q, hdr1_q, hdr2_q, len_q;
	// last two received words: CRC low and high when the frame closes
	byte_t lo_q, hi_q;

	logic  rx_acc;
	pos_t  pos_w;
	pos_t  pos_nx;
	logic  hdr_ok;
	logic  frame_done;
	logic  [END_W-1:0] frame_end;
	logic  [END_W-1:0] pos_ext;
	byte_t rdata;
	crc_t  crc;
	crc_ctrl_t crc_ctrl;
	logic  crc_ok;
	logic  crc_last;
	logic  out_load;
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  [IDX_W-1:0] out_idx_q;
	logic  out_last_q;

	assign rx.ready = (state_q == ST_IDLE);
	assign rx_acc   = rx.valid && rx.ready;

	// wrap before the byte is stored: a full buffer restarts as byte 0
	assign pos_w     = (pos_q >= POS_W'(BUF_DEPTH - 1)) ? '0 : pos_q;
	assign pos_ext   = END_W'(pos_w);
	assign frame_end = {1'b0, len_q} + LEN_OFFSET;
	assign hdr_ok    = (hdr0_q <= DEST_MAX) && (hdr1_q == host_q) &&
		((hdr2_q == wr_op_q) || (hdr2_q == rd_op_q));

	always_comb begin
		frame_done = 1'b0;
		case (pos_w)
			POS_W'(0): pos_nx = (rx.rx_byte <= DEST_MAX) ? POS_W'(1) : '0;
			POS_W'(1): pos_nx = (rx.rx_byte == host_q) ? POS_W'(2) : '0;
			POS_W'(2): pos_nx = ((rx.rx_byte == wr_op_q) || (rx.rx_byte == rd_op_q)) ?
				POS_W'(3) : '0;
			POS_W'(3), POS_W'(4): pos_nx = hdr_ok ? (pos_w + POS_W'(1)) : '0;
			default: begin
				if (pos_ext == frame_end) begin
					frame_done = 1'b1;
					pos_nx     = '0;
				end else if (pos_ext > frame_end) begin
					pos_nx = '0;
				end else begin
					pos_nx = pos_w + POS_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rx_acc) begin
			lo_q <= hi_q;
			hi_q <= rx.rx_byte;
			case (pos_w)
				POS_W'(0): hdr0_q <= rx.rx_byte;
				POS_W'(1): hdr1_q <= rx.rx_byte;
				POS_W'(2): hdr2_q <= rx.rx_byte;
				POS_W'(3): len_q  <= rx.rx_byte;
				default: ;
			endcase
		end
	end

	sfr_frame_ram u_ram (
		.clk   (clk),
		.we    (rx_acc),
		.waddr (pos_w),
		.wdata (rx.rx_byte),
		.re    ((state_q == ST_CRC_RD) || (state_q == ST_EMIT_RD)),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_comb begin
		crc_ctrl.init   = rx_acc && frame_done;
		crc_ctrl.xor_en = (state_q == ST_CRC_XOR);
		crc_ctrl.shift  = (state_q == ST_CRC_SH);
	end

	sfr_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (rdata),
		.poly   (poly_q),
		.crc    (crc)
	);

	// CRC covers bytes 0 .. end-2
	assign crc_last = (idx_q == (end_q - POS_W'(2)));
	assign crc_ok   = (crc[BYTE_W-1:0] == lo_q) && (crc[CRC_W-1:BYTE_W] == hi_q);
	// load the output register when it is empty or being taken
	assign out_load = (state_q == ST_EMIT_LD) && (!out_valid_q || frame.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			idx_q   <= '0;
			end_q   <= '0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rx_acc) begin
						pos_q <= pos_nx;
						if (frame_done) begin
							end_q   <= pos_w;
							idx_q   <= '0;
							state_q <= ST_CRC_RD;
						end
					end
				end
				ST_CRC_RD: state_q <= ST_CRC_XOR;
				ST_CRC_XOR: begin
					bit_q   <= '0;
					state_q <= ST_CRC_SH;
				end
				ST_CRC_SH: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (crc_last) begin
							state_q <= ST_CHECK;
						end else begin
							idx_q   <= idx_q + POS_W'(1);
							state_q <= ST_CRC_RD;
						end
					end
				end
				ST_CHECK: begin
					// drop a bad frame silently
					idx_q   <= '0;
					state_q <= crc_ok ? ST_EMIT_RD : ST_IDLE;
				end
				ST_EMIT_RD: state_q <= ST_EMIT_LD;
				ST_EMIT_LD: begin
					if (out_load) begin
						if (idx_q == end_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + POS_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: holds a word while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= rdata;
			out_idx_q  <= IDX_W'(idx_q);
			out_last_q <= (idx_q == end_q);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.byte_index = out_idx_q;
	assign frame.frame_last = out_last_q;

	`SFR_ASSERT_NXT(a_sh_done, (state_q == ST_CRC_SH) && (bit_q == 3'd7), (state_q == ST_CRC_RD) || (state_q == ST_CHECK), "CRC shift did not close after eight steps")
	`SFR_ASSERT_IMP(a_crc_walk, (state_q == ST_CRC_SH), (idx_q < end_q), "CRC walk ran past the CRC bytes")
	`SFR_ASSERT_NXT(a_emit_end, out_load && (idx_q == end_q), (state_q == ST_IDLE), "emission did not stop at the last word")
	`SFR_ASSERT_NXT(a_next_frame, frame.valid && frame.ready && frame.frame_last, !frame.valid || (frame.byte_index == '0), "word after last is not byte 0")
endmodule
`default_nettype wire
